>>> sv/pab_pkg.sv
// shared types and constants for the pixel alpha blend unit
`default_nettype none

package pab_pkg;

    localparam int unsigned LANES = 4;

    // destination formats
    localparam logic [2:0] FMT_RGBA8888 = 3'd0;
    localparam logic [2:0] FMT_RGB888   = 3'd1;
    localparam logic [2:0] FMT_RGB565   = 3'd2;
    localparam logic [2:0] FMT_PALETTE  = 3'd3;
    localparam logic [2:0] FMT_MASK     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_DEST_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_GLOBAL_ALPHA  = 3'd1;
    localparam logic [2:0] CFG_MASK_ENABLE   = 3'd2;
    localparam logic [2:0] CFG_SOURCE_OPAQUE = 3'd3;
    localparam logic [2:0] CFG_SKIP_INDEX    = 3'd4;

    localparam logic [7:0] ALPHA_FULL = 8'd255;
    localparam logic [8:0] ALPHA_COPY = 9'd255;
    localparam logic [8:0] ALPHA_MIN  = 9'd1;
    localparam logic signed [17:0] ROUND_BIAS = 18'sd127;

    typedef enum logic [1:0] {
        ACT_SKIP,
        ACT_COPY,
        ACT_BLEND
    } act_t;

    typedef struct packed {
        logic [2:0] dest_format;
        logic [7:0] global_alpha;
        logic       mask_enable;
        logic       source_opaque;
        logic [7:0] skip_index;
    } cfg_t;

    typedef struct packed {
        act_t                  act;
        logic [2:0]            fmt;
        logic [7:0]            weight;
        logic [LANES-1:0][7:0] lane_src;
        logic [LANES-1:0][7:0] lane_dst;
        logic [31:0]           dest_pixel;
    } item_t;

endpackage

`default_nettype wire

>>> sv/pab_alpha.sv
// effective alpha stages: alpha product, mask product, action and lane operands
`default_nettype none

module pab_alpha (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pab_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_red,
    input  wire logic [7:0]    in_green,
    input  wire logic [7:0]    in_blue,
    input  wire logic [7:0]    in_alpha,
    input  wire logic [7:0]    in_mask,
    input  wire logic [31:0]   in_dest,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pab_pkg::item_t     out_item
);

    logic        v1_reg;
    logic [7:0]  red1_reg, green1_reg, blue1_reg, alpha1_reg, seff1_reg, mask1_reg;
    logic [31:0] dest1_reg;
    logic [16:0] prod1_reg;
    logic [16:0] prod1_next;

    logic           v2_reg;
    pab_pkg::item_t item2_reg;
    pab_pkg::item_t item2_next;

    logic        en1, en2;
    logic [7:0]  seff;
    logic [8:0]  seff_p1, galpha_p1, mask_p1;
    logic [17:0] prod_full;
    logic [25:0] mprod;
    logic [8:0]  alpha;
    logic        is_565;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: source alpha times global alpha
    assign seff       = cfg.source_opaque ? pab_pkg::ALPHA_FULL : in_alpha;
    assign seff_p1    = {1'b0, seff} + 9'd1;
    assign galpha_p1  = {1'b0, cfg.global_alpha} + 9'd1;
    assign prod_full  = seff_p1 * galpha_p1;
    assign prod1_next = prod_full[16:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            red1_reg   <= in_red;
            green1_reg <= in_green;
            blue1_reg  <= in_blue;
            alpha1_reg <= in_alpha;
            seff1_reg  <= seff;
            mask1_reg  <= in_mask;
            dest1_reg  <= in_dest;
            prod1_reg  <= prod1_next;
        end
    end

    // stage 2: optional mask weight, then action and lane operands
    assign mask_p1 = {1'b0, mask1_reg} + 9'd1;
    assign mprod   = prod1_reg * mask_p1;
    assign alpha   = cfg.mask_enable ? mprod[24:16] : prod1_reg[16:8];
    assign is_565  = (cfg.dest_format == pab_pkg::FMT_RGB565);

    always_comb begin
        item2_next.fmt        = cfg.dest_format;
        item2_next.dest_pixel = dest1_reg;
        item2_next.weight     = (cfg.dest_format == pab_pkg::FMT_MASK) ?
                                cfg.global_alpha : alpha[7:0];

        item2_next.lane_src[0] = ((cfg.dest_format == pab_pkg::FMT_PALETTE) ||
                                  (cfg.dest_format == pab_pkg::FMT_MASK)) ?
                                 alpha1_reg : red1_reg;
        item2_next.lane_src[1] = green1_reg;
        item2_next.lane_src[2] = blue1_reg;
        item2_next.lane_src[3] = seff1_reg;

        item2_next.lane_dst[0] = is_565 ? {dest1_reg[4:0], 3'b000}   : dest1_reg[7:0];
        item2_next.lane_dst[1] = is_565 ? {dest1_reg[10:5], 2'b00}   : dest1_reg[15:8];
        item2_next.lane_dst[2] = is_565 ? {dest1_reg[15:11], 3'b000} : dest1_reg[23:16];
        item2_next.lane_dst[3] = dest1_reg[31:24];

        unique case (cfg.dest_format)
            pab_pkg::FMT_RGBA8888, pab_pkg::FMT_RGB888, pab_pkg::FMT_RGB565: begin
                if (alpha >= pab_pkg::ALPHA_COPY) begin
                    item2_next.act = pab_pkg::ACT_COPY;
                end else if (alpha > pab_pkg::ALPHA_MIN) begin
                    item2_next.act = pab_pkg::ACT_BLEND;
                end else begin
                    item2_next.act = pab_pkg::ACT_SKIP;
                end
            end
            pab_pkg::FMT_PALETTE: begin
                item2_next.act = (alpha1_reg != cfg.skip_index) ?
                                 pab_pkg::ACT_COPY : pab_pkg::ACT_SKIP;
            end
            pab_pkg::FMT_MASK: begin
                item2_next.act = pab_pkg::ACT_BLEND;
            end
            default: begin
                item2_next.act = pab_pkg::ACT_SKIP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

`default_nettype wire

>>> sv/pab_mix.sv
// lane mix stages: weighted difference per channel, then rounding and packing
`default_nettype none

module pab_mix (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pab_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         out_pixel,
    output logic                out_we
);

    logic           v3_reg;
    pab_pkg::item_t item3_reg;
    logic signed [17:0] prod3_reg  [pab_pkg::LANES];
    logic signed [17:0] prod3_next [pab_pkg::LANES];

    logic        v4_reg;
    logic [31:0] pixel4_reg, pixel4_next;
    logic        we4_reg, we4_next;

    logic        en3, en4;
    logic [7:0]  mixed [pab_pkg::LANES];
    logic [7:0]  nr, ng, nb;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // stage 3: weight times signed difference
    for (genvar k = 0; k < pab_pkg::LANES; k++) begin : g_lane
        logic signed [8:0]  diff;
        logic signed [17:0] tsum;
        logic signed [17:0] quot;

        assign diff = $signed({1'b0, in_item.lane_src[k]}) -
                      $signed({1'b0, in_item.lane_dst[k]});
        assign prod3_next[k] = $signed({1'b0, in_item.weight}) * diff;

        // stage 4: floor of rounded product over 256, added to destination
        assign tsum     = prod3_reg[k] + pab_pkg::ROUND_BIAS;
        assign quot     = tsum >>> 8;
        assign mixed[k] = item3_reg.lane_dst[k] + quot[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && in_valid) begin
            item3_reg <= in_item;
            prod3_reg <= prod3_next;
        end
    end

    always_comb begin
        pixel4_next = item3_reg.dest_pixel;
        we4_next    = 1'b0;
        nr          = item3_reg.lane_src[0];
        ng          = item3_reg.lane_src[1];
        nb          = item3_reg.lane_src[2];
        if (item3_reg.act == pab_pkg::ACT_BLEND) begin
            nr = mixed[0];
            ng = mixed[1];
            nb = mixed[2];
        end

        unique case (item3_reg.act)
            pab_pkg::ACT_COPY, pab_pkg::ACT_BLEND: begin
                we4_next = 1'b1;
                unique case (item3_reg.fmt)
                    pab_pkg::FMT_RGBA8888: begin
                        pixel4_next = {(item3_reg.act == pab_pkg::ACT_BLEND) ?
                                       mixed[3] : item3_reg.lane_dst[3], nb, ng, nr};
                    end
                    pab_pkg::FMT_RGB888: begin
                        pixel4_next = {item3_reg.lane_dst[3], nb, ng, nr};
                    end
                    pab_pkg::FMT_RGB565: begin
                        pixel4_next = {item3_reg.dest_pixel[31:16],
                                       nb[7:3], ng[7:2], nr[7:3]};
                    end
                    pab_pkg::FMT_PALETTE, pab_pkg::FMT_MASK: begin
                        pixel4_next = {item3_reg.dest_pixel[31:8], nr};
                    end
                    default: begin
                        pixel4_next = item3_reg.dest_pixel;
                        we4_next    = 1'b0;
                    end
                endcase
            end
            default: begin
                pixel4_next = item3_reg.dest_pixel;
                we4_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            pixel4_reg <= pixel4_next;
            we4_reg    <= we4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_pixel = pixel4_reg;
    assign out_we    = we4_reg;

endmodule

`default_nettype wire

>>> sv/pixel_alpha_blend_unit_core.sv
// pixel alpha blend unit: config registers and the four stage blend pipeline
//
// one source pixel (s_src_*, s_mask_weight) and the current destination word
// (s_dest_pixel) enter per s_valid/s_ready transaction; one m_new_pixel with
// m_write_enable leaves per m_valid/m_ready transaction, in order.
// configuration goes through cfg_valid/cfg_ready with cfg_index selecting
// dest_format, global_alpha, mask_enable, source_opaque, skip_index;
// cfg_ready is always high. write config only while the pipeline is empty.
// each input transaction passes through the register stages in order before
// m_valid rises: alpha product, mask product and action, per channel multiply,
// round and pack. throughput is one pixel per cycle while m_ready is high,
// set by the four register stages that each take a new transaction whenever
// the one ahead moves.
// reset empties the pipeline and loads dest_format rgba8888, global_alpha 255
// and zero for the other registers.
// when m_ready is low the output holds and the stall backs up stage by stage;
// s_ready drops only once every stage is full.
`default_nettype none

module pixel_alpha_blend_unit_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_src_red,
    input  wire logic [7:0]  s_src_green,
    input  wire logic [7:0]  s_src_blue,
    input  wire logic [7:0]  s_src_alpha,
    input  wire logic [7:0]  s_mask_weight,
    input  wire logic [31:0] s_dest_pixel,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_new_pixel,
    output logic             m_write_enable
);

    pab_pkg::cfg_t  cfg_reg;
    logic           mid_valid, mid_ready;
    pab_pkg::item_t mid_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_format   <= pab_pkg::FMT_RGBA8888;
            cfg_reg.global_alpha  <= pab_pkg::ALPHA_FULL;
            cfg_reg.mask_enable   <= 1'b0;
            cfg_reg.source_opaque <= 1'b0;
            cfg_reg.skip_index    <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pab_pkg::CFG_DEST_FORMAT:   cfg_reg.dest_format <= cfg_data[2:0];
                pab_pkg::CFG_GLOBAL_ALPHA:  cfg_reg.global_alpha <= cfg_data;
                pab_pkg::CFG_MASK_ENABLE:   cfg_reg.mask_enable <= cfg_data[0];
                pab_pkg::CFG_SOURCE_OPAQUE: cfg_reg.source_opaque <= cfg_data[0];
                pab_pkg::CFG_SKIP_INDEX:    cfg_reg.skip_index <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pab_alpha u_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_src_red),
        .in_green  (s_src_green),
        .in_blue   (s_src_blue),
        .in_alpha  (s_src_alpha),
        .in_mask   (s_mask_weight),
        .in_dest   (s_dest_pixel),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    pab_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_new_pixel),
        .out_we    (m_write_enable)
    );

`ifndef ASSERT_OFF
    // backpressure on the input only comes from a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output stall");

    // mask destination is always written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg_reg.dest_format == pab_pkg::FMT_MASK) |-> m_write_enable)
        else $error("mask destination pixel not written");

    // unused formats never write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg_reg.dest_format > pab_pkg::FMT_MASK) |-> !m_write_enable)
        else $error("unused format wrote a pixel");

    // the middle handoff never stalls while the mix side has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid && !mid_ready) |-> (m_valid && !m_ready))
        else $error("internal stall without output stall");
`endif

endmodule

`default_nettype wire
